### rtl/tba_pkg.sv
// ---------------------------------------------------------------------------
// tba_pkg
// Shared types and operation codes for the ternary bit-vector ALU.
// ---------------------------------------------------------------------------
package tba_pkg;

  // Operation codes carried in the mode field
  localparam logic [4:0] MODE_NOT       = 5'd0;
  localparam logic [4:0] MODE_AND       = 5'd1;
  localparam logic [4:0] MODE_OR        = 5'd2;
  localparam logic [4:0] MODE_XOR       = 5'd3;
  localparam logic [4:0] MODE_MEET      = 5'd4;
  localparam logic [4:0] MODE_SHL       = 5'd5;
  localparam logic [4:0] MODE_SHR       = 5'd6;
  localparam logic [4:0] MODE_ASHR      = 5'd7;
  localparam logic [4:0] MODE_CONCAT    = 5'd8;
  localparam logic [4:0] MODE_EXTRACT   = 5'd9;
  localparam logic [4:0] MODE_ZEXT      = 5'd10;
  localparam logic [4:0] MODE_SEXT      = 5'd11;
  localparam logic [4:0] MODE_FIXBIT    = 5'd12;
  localparam logic [4:0] MODE_FIX       = 5'd13;
  localparam logic [4:0] MODE_COPYFIXED = 5'd14;
  localparam logic [4:0] MODE_MATCH     = 5'd15;
  localparam logic [4:0] MODE_EQ        = 5'd16;
  localparam logic [4:0] MODE_VALID     = 5'd17;
  localparam logic [4:0] MODE_FIXED     = 5'd18;
  localparam logic [4:0] MODE_HASFIXED  = 5'd19;
  localparam logic [4:0] MODE_HASTRUE   = 5'd20;
  localparam logic [4:0] MODE_HASFALSE  = 5'd21;
  localparam logic [4:0] MODE_BITFIXED  = 5'd22;
  localparam logic [4:0] MODE_BITTRUE   = 5'd23;
  localparam logic [4:0] MODE_BITFALSE  = 5'd24;

  // One operation request
  typedef struct packed {
    logic [4:0]  mode;
    logic [6:0]  a_width;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [6:0]  b_width;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
    logic [7:0]  amount;
    logic [5:0]  top_bit;
    logic [63:0] value;
  } cmd_t;

  // One operation result
  typedef struct packed {
    logic [6:0]  res_width;
    logic [63:0] res_lo;
    logic [63:0] res_hi;
    logic        flag;
    logic [63:0] copied_value;
    logic        error;
  } res_t;

  // Low-order ones mask of the given width; all ones from 64 upwards
  function automatic logic [63:0] wmask(input logic [6:0] w);
    wmask = ~({64{1'b1}} << w);
  endfunction

endpackage

### rtl/ternary_bitvector_alu.sv
// ---------------------------------------------------------------------------
// ternary_bitvector_alu
// Known-bits ALU over ternary bit-vectors with registered request and result.
//
//   Channel   Ports             Transfer rule
//   request   start/busy, cmd   start high while busy low
//   result    done, result      done high for one cycle, always taken
//
// One request per cycle; busy is held low. Each request goes into the request
// register, then through one pass of the datapath into the result register,
// whose output drives the result ports.
// rst (synchronous) drops both valid flags; payload registers are not reset.
// The receiver cannot stall, so nothing ever back-pressures the request side.
// ---------------------------------------------------------------------------
module ternary_bitvector_alu #(
  parameter int MAX_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tba_pkg::cmd_t cmd,
  output logic          done,
  output tba_pkg::res_t result
);

  logic          in_valid;
  tba_pkg::cmd_t in_cmd;
  tba_pkg::res_t res_next;

  assign busy = 1'b0;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd <= cmd;
    end
  end

  // Datapath
  tba_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_core (
    .cmd(in_cmd),
    .res(res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= res_next;
    end
  end

endmodule

### rtl/tba_core.sv
// ---------------------------------------------------------------------------
// tba_core
// Single-pass datapath: decodes the mode and forms the result domain,
// predicate flag, copied value and error from one registered request.
// ---------------------------------------------------------------------------
module tba_core #(
  parameter int MAX_WIDTH = 64
) (
  input  tba_pkg::cmd_t cmd,
  output tba_pkg::res_t res
);

  logic [6:0]  aw, bw;
  logic [7:0]  n;
  logic [63:0] am, bm, fa;
  logic [5:0]  sidx;
  logic        sl, sh;
  logic        n_lt_aw;
  logic        uses_b;
  logic [7:0]  cat_sum;
  logic [8:0]  ext_sum;
  logic [63:0] bitm;

  logic [6:0]  rw;
  logic [63:0] rl, rh, cv;
  logic        flag, err;
  logic [63:0] fr, xval, ls, hs, fill;

  // Common operand decode
  assign aw      = cmd.a_width;
  assign bw      = cmd.b_width;
  assign n       = cmd.amount;
  assign am      = tba_pkg::wmask(aw);
  assign bm      = tba_pkg::wmask(bw);
  assign fa      = ~(cmd.a_lo ^ cmd.a_hi) & am;
  assign sidx    = 6'(aw - 7'd1);
  assign sl      = cmd.a_lo[sidx];
  assign sh      = cmd.a_hi[sidx];
  assign n_lt_aw = n < {1'b0, aw};
  assign cat_sum = {1'b0, aw} + {1'b0, bw};
  assign ext_sum = {2'b00, aw} + {1'b0, n};
  assign bitm    = 64'd1 << n;
  assign uses_b  = (cmd.mode >= tba_pkg::MODE_AND && cmd.mode <= tba_pkg::MODE_MEET) ||
                   cmd.mode == tba_pkg::MODE_CONCAT || cmd.mode == tba_pkg::MODE_EQ;

  // Bitwise helpers for xor and the logical and arithmetic right shifts
  assign fr   = fa & ~(cmd.b_lo ^ cmd.b_hi) & bm;
  assign xval = (cmd.a_lo ^ cmd.b_lo) & fr;
  assign ls   = (cmd.a_lo & am) >> n;
  assign hs   = (cmd.a_hi & am) >> n;
  assign fill = (n == 8'd0) ? 64'd0 : ((am << (aw - n[6:0])) & am);

  // Operation select
  always_comb begin
    rw   = '0;
    rl   = '0;
    rh   = '0;
    cv   = '0;
    flag = 1'b0;
    err  = 1'b0;
    if (cmd.mode > tba_pkg::MODE_BITFALSE || aw > 7'(MAX_WIDTH) ||
        (uses_b && bw > 7'(MAX_WIDTH))) begin
      err = 1'b1;
    end else if (cmd.mode >= tba_pkg::MODE_AND && cmd.mode <= tba_pkg::MODE_MEET &&
                 aw != bw) begin
      err = 1'b1;
    end else begin
      case (cmd.mode)
        tba_pkg::MODE_NOT: begin
          rw = aw; rl = ~cmd.a_hi; rh = ~cmd.a_lo;
        end
        tba_pkg::MODE_AND: begin
          rw = aw; rl = cmd.a_lo & cmd.b_lo; rh = cmd.a_hi & cmd.b_hi;
        end
        tba_pkg::MODE_OR: begin
          rw = aw; rl = cmd.a_lo | cmd.b_lo; rh = cmd.a_hi | cmd.b_hi;
        end
        tba_pkg::MODE_XOR: begin
          rw = aw; rl = xval; rh = xval | ~fr;
        end
        tba_pkg::MODE_MEET: begin
          rw = aw; rl = cmd.a_lo | cmd.b_lo; rh = cmd.a_hi & cmd.b_hi;
        end
        tba_pkg::MODE_SHL: begin
          rw = aw;
          if (n_lt_aw) begin
            rl = cmd.a_lo << n; rh = cmd.a_hi << n;
          end
        end
        tba_pkg::MODE_SHR: begin
          rw = aw;
          if (n_lt_aw) begin
            rl = ls; rh = hs;
          end
        end
        tba_pkg::MODE_ASHR: begin
          rw = aw;
          if (aw != 7'd0) begin
            if (!n_lt_aw) begin
              // whole vector takes the sign state; invalid reads as unknown
              if (sl == sh) begin
                rl = sl ? am : 64'd0; rh = sl ? am : 64'd0;
              end else begin
                rl = 64'd0; rh = am;
              end
            end else if (sl && sh) begin
              rl = ls | fill; rh = hs | fill;
            end else if (!sl && !sh) begin
              rl = ls; rh = hs;
            end else begin
              rl = ls & ~fill; rh = hs | fill;
            end
          end
        end
        tba_pkg::MODE_CONCAT: begin
          if (cat_sum > 8'(MAX_WIDTH)) begin
            err = 1'b1;
          end else begin
            rw = cat_sum[6:0];
            rl = ((cmd.a_lo & am) << bw) | (cmd.b_lo & bm);
            rh = ((cmd.a_hi & am) << bw) | (cmd.b_hi & bm);
          end
        end
        tba_pkg::MODE_EXTRACT: begin
          if (n > {2'b00, cmd.top_bit} || {1'b0, cmd.top_bit} >= aw) begin
            err = 1'b1;
          end else begin
            rw = {1'b0, cmd.top_bit} - {1'b0, n[5:0]} + 7'd1;
            rl = cmd.a_lo >> n; rh = cmd.a_hi >> n;
          end
        end
        tba_pkg::MODE_ZEXT, tba_pkg::MODE_SEXT: begin
          if (ext_sum > 9'(MAX_WIDTH)) begin
            err = 1'b1;
          end else begin
            rw = ext_sum[6:0];
            rl = cmd.a_lo & am; rh = cmd.a_hi & am;
            // sign fill; empty operand extends with fixed 0
            if (cmd.mode == tba_pkg::MODE_SEXT && n != 8'd0 && aw != 7'd0) begin
              if (sl && sh) begin
                rl = rl | (tba_pkg::wmask(ext_sum[6:0]) & ~am);
                rh = rh | (tba_pkg::wmask(ext_sum[6:0]) & ~am);
              end else if (sl != sh) begin
                rh = rh | (tba_pkg::wmask(ext_sum[6:0]) & ~am);
              end
            end
          end
        end
        tba_pkg::MODE_FIXBIT: begin
          rw = aw; rl = cmd.a_lo; rh = cmd.a_hi;
          if (n_lt_aw) begin
            if (cmd.value[0]) begin
              rl = cmd.a_lo | bitm; rh = cmd.a_hi | bitm;
            end else begin
              rl = cmd.a_lo & ~bitm; rh = cmd.a_hi & ~bitm;
            end
          end
        end
        tba_pkg::MODE_FIX: begin
          rw = aw; rl = cmd.value; rh = cmd.value;
        end
        tba_pkg::MODE_COPYFIXED: begin
          cv = ((cmd.value & ~fa) | (cmd.a_lo & fa)) & am;
        end
        tba_pkg::MODE_MATCH: begin
          flag = (fa & cmd.a_lo) == (fa & cmd.value);
        end
        tba_pkg::MODE_EQ: begin
          flag = aw == bw && (cmd.a_lo & am) == (cmd.b_lo & am) &&
                 (cmd.a_hi & am) == (cmd.b_hi & am);
        end
        tba_pkg::MODE_VALID: begin
          flag = (cmd.a_lo & ~cmd.a_hi & am) == 64'd0;
        end
        tba_pkg::MODE_FIXED: begin
          flag = (cmd.a_lo & am) == (cmd.a_hi & am);
        end
        tba_pkg::MODE_HASFIXED: begin
          flag = fa != 64'd0;
        end
        tba_pkg::MODE_HASTRUE: begin
          flag = (cmd.a_lo & cmd.a_hi & am) != 64'd0;
        end
        tba_pkg::MODE_HASFALSE: begin
          flag = (~cmd.a_lo & ~cmd.a_hi & am) != 64'd0;
        end
        tba_pkg::MODE_BITFIXED: begin
          flag = n_lt_aw && (cmd.a_lo[n[5:0]] == cmd.a_hi[n[5:0]]);
        end
        tba_pkg::MODE_BITTRUE: begin
          flag = n_lt_aw && cmd.a_lo[n[5:0]] && cmd.a_hi[n[5:0]];
        end
        tba_pkg::MODE_BITFALSE: begin
          flag = n_lt_aw && !cmd.a_lo[n[5:0]] && !cmd.a_hi[n[5:0]];
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
  end

  // Output shaping: errors clear everything else, masks cut to result width
  always_comb begin
    if (err) begin
      res = '0;
      res.error = 1'b1;
    end else begin
      res.res_width    = rw;
      res.res_lo       = rl & tba_pkg::wmask(rw);
      res.res_hi       = rh & tba_pkg::wmask(rw);
      res.flag         = flag;
      res.copied_value = cv;
      res.error        = 1'b0;
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the ternary bit-vector ALU. Requests are fed from
// a backlog by a falling-edge driver with random idle bursts; every result
// strobe is checked field by field against a local known-bits model.
// ---------------------------------------------------------------------------
module testbench;

  localparam int MAX_W      = 64;
  localparam int RAND_OPS   = 1450;
  localparam int QUIET_TAIL = 150;   // final transfers sent with no idling
  localparam int MAX_REPORT = 40;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  tba_pkg::cmd_t cmd = '0;
  logic busy;
  logic done;
  tba_pkg::res_t result;

  tba_pkg::cmd_t cmd_backlog[$];
  tba_pkg::res_t expected_results[$];

  logic        taken = 1'b0;
  int          idle_left = 0;
  int          n_fail = 0;
  int          n_reported = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_err_res = 0;
  logic [31:0] modes_hit = '0;

  ternary_bitvector_alu #(.MAX_WIDTH(MAX_W)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Low-order ones of width w, saturating at 64
  function automatic logic [63:0] ones(input int w);
    if (w >= 64) return {64{1'b1}};
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Known-bits model: expected outcome of one request
  function automatic tba_pkg::res_t alu_outcome(input tba_pkg::cmd_t c);
    tba_pkg::res_t r;
    int          aw, bw, n, top, rw;
    logic [63:0] am, bm, fa, fr, val, rl, rh, cv, sb, fill, ls, hs, pos;
    logic        flag, err, uses_b, sl, sh, bl, bh;
    aw = c.a_width;
    bw = c.b_width;
    n = c.amount;
    top = c.top_bit;
    rw = 0;
    rl = '0;
    rh = '0;
    cv = '0;
    flag = 1'b0;
    err = 1'b0;
    uses_b = (c.mode >= tba_pkg::MODE_AND && c.mode <= tba_pkg::MODE_MEET) ||
             c.mode == tba_pkg::MODE_CONCAT || c.mode == tba_pkg::MODE_EQ;
    am = ones(aw);
    bm = ones(bw);
    fa = ~(c.a_lo ^ c.a_hi) & am;
    if (c.mode > tba_pkg::MODE_BITFALSE || aw > MAX_W || (uses_b && bw > MAX_W)) begin
      err = 1'b1;
    end else if (c.mode >= tba_pkg::MODE_AND && c.mode <= tba_pkg::MODE_MEET &&
                 aw != bw) begin
      err = 1'b1;
    end else begin
      case (c.mode)
        tba_pkg::MODE_NOT: begin
          rw = aw; rl = ~c.a_hi; rh = ~c.a_lo;
        end
        tba_pkg::MODE_AND: begin
          rw = aw; rl = c.a_lo & c.b_lo; rh = c.a_hi & c.b_hi;
        end
        tba_pkg::MODE_OR: begin
          rw = aw; rl = c.a_lo | c.b_lo; rh = c.a_hi | c.b_hi;
        end
        tba_pkg::MODE_XOR: begin
          fr = fa & ~(c.b_lo ^ c.b_hi) & bm;
          val = (c.a_lo ^ c.b_lo) & fr;
          rw = aw; rl = val; rh = val | ~fr;
        end
        tba_pkg::MODE_MEET: begin
          rw = aw; rl = c.a_lo | c.b_lo; rh = c.a_hi & c.b_hi;
        end
        tba_pkg::MODE_SHL: begin
          rw = aw;
          if (n < aw) begin
            rl = c.a_lo << n; rh = c.a_hi << n;
          end
        end
        tba_pkg::MODE_SHR: begin
          rw = aw;
          if (n < aw) begin
            rl = (c.a_lo & am) >> n; rh = (c.a_hi & am) >> n;
          end
        end
        tba_pkg::MODE_ASHR: begin
          rw = aw;
          if (aw != 0) begin
            sb = 64'd1 << (aw - 1);
            sl = |(c.a_lo & sb);
            sh = |(c.a_hi & sb);
            if (n >= aw) begin
              // whole result takes the sign state; invalid reads as unknown
              if (sl == sh) begin
                rl = sl ? am : '0; rh = rl;
              end else begin
                rl = '0; rh = am;
              end
            end else begin
              ls = (c.a_lo & am) >> n;
              hs = (c.a_hi & am) >> n;
              fill = (n == 0) ? '0 : ((am << (aw - n)) & am);
              if (sl && sh) begin
                rl = ls | fill; rh = hs | fill;
              end else if (!sl && !sh) begin
                rl = ls; rh = hs;
              end else begin
                rl = ls & ~fill; rh = hs | fill;
              end
            end
          end
        end
        tba_pkg::MODE_CONCAT: begin
          if (aw + bw > MAX_W) begin
            err = 1'b1;
          end else begin
            rw = aw + bw;
            rl = ((c.a_lo & am) << bw) | (c.b_lo & bm);
            rh = ((c.a_hi & am) << bw) | (c.b_hi & bm);
          end
        end
        tba_pkg::MODE_EXTRACT: begin
          if (n > top || top >= aw) begin
            err = 1'b1;
          end else begin
            rw = top - n + 1; rl = c.a_lo >> n; rh = c.a_hi >> n;
          end
        end
        tba_pkg::MODE_ZEXT, tba_pkg::MODE_SEXT: begin
          if (aw + n > MAX_W) begin
            err = 1'b1;
          end else begin
            rw = aw + n;
            rl = c.a_lo & am;
            rh = c.a_hi & am;
            if (c.mode == tba_pkg::MODE_SEXT && n != 0 && aw != 0) begin
              sb = 64'd1 << (aw - 1);
              sl = |(c.a_lo & sb);
              sh = |(c.a_hi & sb);
              fill = ones(rw) & ~am;
              if (sl && sh) begin
                rl = rl | fill; rh = rh | fill;
              end else if (sl != sh) begin
                rh = rh | fill;
              end
            end
          end
        end
        tba_pkg::MODE_FIXBIT: begin
          rw = aw; rl = c.a_lo; rh = c.a_hi;
          if (n < aw) begin
            pos = 64'd1 << n;
            if (c.value[0]) begin
              rl = rl | pos; rh = rh | pos;
            end else begin
              rl = rl & ~pos; rh = rh & ~pos;
            end
          end
        end
        tba_pkg::MODE_FIX: begin
          rw = aw; rl = c.value; rh = c.value;
        end
        tba_pkg::MODE_COPYFIXED: begin
          cv = ((c.value & ~fa) | (c.a_lo & fa)) & am;
        end
        tba_pkg::MODE_MATCH:    flag = (fa & c.a_lo) == (fa & c.value);
        tba_pkg::MODE_EQ: begin
          flag = aw == bw && (c.a_lo & am) == (c.b_lo & am) &&
                 (c.a_hi & am) == (c.b_hi & am);
        end
        tba_pkg::MODE_VALID:    flag = (c.a_lo & ~c.a_hi & am) == '0;
        tba_pkg::MODE_FIXED:    flag = (c.a_lo & am) == (c.a_hi & am);
        tba_pkg::MODE_HASFIXED: flag = fa != '0;
        tba_pkg::MODE_HASTRUE:  flag = (c.a_lo & c.a_hi & am) != '0;
        tba_pkg::MODE_HASFALSE: flag = (~c.a_lo & ~c.a_hi & am) != '0;
        default: begin
          // per-bit tests; an index past the width answers 0
          if (n < aw) begin
            bl = c.a_lo[n];
            bh = c.a_hi[n];
            if (c.mode == tba_pkg::MODE_BITFIXED)     flag = bl == bh;
            else if (c.mode == tba_pkg::MODE_BITTRUE) flag = bl && bh;
            else                                      flag = !bl && !bh;
          end
        end
      endcase
    end
    if (err) begin
      rw = 0; rl = '0; rh = '0; flag = 1'b0; cv = '0;
    end
    r.res_width    = 7'(rw);
    r.res_lo       = rl & ones(rw);
    r.res_hi       = rh & ones(rw);
    r.flag         = flag;
    r.copied_value = cv;
    r.error        = err;
    return r;
  endfunction

  function automatic tba_pkg::cmd_t make_op(input logic [4:0] m, input int aw,
                                            input logic [63:0] alo, input logic [63:0] ahi,
                                            input int bw, input logic [63:0] blo,
                                            input logic [63:0] bhi, input int n,
                                            input int top, input logic [63:0] v);
    tba_pkg::cmd_t c;
    c.mode = m;
    c.a_width = 7'(aw);
    c.a_lo = alo;
    c.a_hi = ahi;
    c.b_width = 7'(bw);
    c.b_lo = blo;
    c.b_hi = bhi;
    c.amount = 8'(n);
    c.top_bit = 6'(top);
    c.value = v;
    return c;
  endfunction

  // Random lo/hi pair: free (invalid bits too), valid mix, all fixed, or few unknowns
  function automatic logic [127:0] ternary_pair();
    logic [63:0] r, u, lo, hi;
    r = rand64();
    u = rand64();
    case ($urandom_range(0, 3))
      0: begin
        lo = r; hi = u;
      end
      1: begin
        lo = r & u; hi = r | u;
      end
      2: begin
        lo = r; hi = r;
      end
      default: begin
        u = u & rand64() & rand64();
        lo = r & ~u; hi = r | u;
      end
    endcase
    return {lo, hi};
  endfunction

  function automatic tba_pkg::cmd_t random_op();
    tba_pkg::cmd_t c;
    logic [127:0] m;
    logic [63:0]  fa;
    int           aw, bw, n, top, hi_idx;
    c.mode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(25, 31))
                                          : 5'($urandom_range(0, 24));
    case ($urandom_range(0, 19))
      0:       aw = 0;
      1:       aw = 1;
      2:       aw = 64;
      3:       aw = 63;
      4:       aw = $urandom_range(65, 127);
      default: aw = $urandom_range(1, 64);
    endcase
    m = ternary_pair();
    c.a_lo = m[127:64];
    c.a_hi = m[63:0];
    m = ternary_pair();
    c.b_lo = m[127:64];
    c.b_hi = m[63:0];

    // second operand width: mostly matched, concat mostly within range
    if ((c.mode >= tba_pkg::MODE_AND && c.mode <= tba_pkg::MODE_MEET) ||
        c.mode == tba_pkg::MODE_EQ) begin
      bw = ($urandom_range(0, 4) != 0) ? aw : $urandom_range(0, 127);
      if (c.mode == tba_pkg::MODE_EQ && $urandom_range(0, 2) == 0) begin
        c.b_lo = c.a_lo; c.b_hi = c.a_hi;
      end
    end else if (c.mode == tba_pkg::MODE_CONCAT && aw <= MAX_W &&
                 $urandom_range(0, 6) != 0) begin
      bw = $urandom_range(0, MAX_W - aw);
    end else begin
      bw = $urandom_range(0, 127);
    end

    // amount hugs the width boundary most of the time
    if ((c.mode == tba_pkg::MODE_ZEXT || c.mode == tba_pkg::MODE_SEXT) && aw <= MAX_W &&
        $urandom_range(0, 4) != 0) begin
      n = $urandom_range(0, MAX_W + 1 - aw);
    end else if ($urandom_range(0, 3) != 0) begin
      n = $urandom_range(0, aw + 1);
    end else begin
      n = $urandom_range(0, 255);
    end

    hi_idx = (aw > 64) ? 63 : aw - 1;
    if (c.mode == tba_pkg::MODE_EXTRACT && n <= hi_idx && $urandom_range(0, 4) != 0)
      top = $urandom_range(n, hi_idx);
    else
      top = $urandom_range(0, 63);

    c.a_width = 7'(aw);
    c.b_width = 7'(bw);
    c.amount = 8'(n);
    c.top_bit = 6'(top);
    c.value = rand64();
    if (c.mode == tba_pkg::MODE_MATCH && $urandom_range(0, 1) == 0) begin
      fa = ~(c.a_lo ^ c.a_hi) & ones(aw);
      c.value = (c.a_lo & fa) | (c.value & ~fa);
    end
    return c;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_reported < MAX_REPORT) begin
        n_reported++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    end
  endtask

  // Result checker and request bookkeeping
  always @(posedge clk) begin : result_monitor
    tba_pkg::res_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          n_fail++;
          if (n_reported < MAX_REPORT) begin
            n_reported++;
            $display("%0t: result with none expected: expected none, actual %h", $time,
                     result);
          end
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.error) n_err_res++;
          compare_field("res_width", 64'(want.res_width), 64'(result.res_width));
          compare_field("res_lo", want.res_lo, result.res_lo);
          compare_field("res_hi", want.res_hi, result.res_hi);
          compare_field("flag", 64'(want.flag), 64'(result.flag));
          compare_field("copied_value", want.copied_value, result.copied_value);
          compare_field("error", 64'(want.error), 64'(result.error));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(alu_outcome(cmd));
        modes_hit[cmd.mode] = 1'b1;
        n_sent++;
      end
      taken <= start && !busy;
    end
  end

  // Request driver: one transfer per cycle unless an idle burst is running or the backlog is empty
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) void'(cmd_backlog.pop_front());
      if (idle_left == 0 && (!start || taken) && cmd_backlog.size() > QUIET_TAIL &&
          $urandom_range(0, 9) == 0)
        idle_left = $urandom_range(1, 19);
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        cmd <= cmd_backlog[0];
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // edges of each operation and the named corner cases
    cmd_backlog.push_back(make_op(tba_pkg::MODE_NOT, 64, 64'h00FF_0F0F_3333_5555,
                                  64'h0F0F_FFFF_33FF_55AA, 0, '0, '0, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_AND, 64, 64'hFFFF_0000_FFFF_0000, '1, 64,
                                  64'h0F0F_0F0F_0000_FFFF, 64'h0F0F_FFFF_FFFF_FFFF,
                                  0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_OR, 8, 64'h12, 64'hF3, 8, 64'h40, 64'h4C,
                                  0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_XOR, 64, 64'hAAAA_5555_F0F0_0F0F,
                                  64'h5555_FFFF_F0F0_FF0F, 64, 64'h3333_3333_0000_FFFF,
                                  64'h3333_FFFF_0000_FFFF, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_MEET, 16, 64'h0F00, 64'hFFF0, 16,
                                  64'h00F0, 64'h0FFF, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_AND, 8, 64'h0F, 64'hFF, 9, 64'h0F, 64'hFF,
                                  0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_SHL, 64, '1, '1, 0, '0, '0, 63, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_SHR, 10, 64'h3FF, 64'h3FF, 0, '0, '0,
                                  10, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_ASHR, 12, 64'h055, 64'h8F5, 0, '0, '0,
                                  0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_ASHR, 12, 64'h800, 64'h0FF, 0, '0, '0,
                                  20, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_ASHR, 0, '1, '1, 0, '0, '0, 3, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_CONCAT, 32, 64'h1234_5678, 64'hFFFF_5678,
                                  32, 64'h0, 64'hFFFF_FFFF, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_CONCAT, 40, '0, '1, 30, '0, '1, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_EXTRACT, 20, 64'hA_BCDE, 64'hF_FCDE, 0,
                                  '0, '0, 3, 10, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_EXTRACT, 20, '1, '1, 0, '0, '0, 12, 5,
                                  '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_ZEXT, 60, '1, '1, 0, '0, '0, 4, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_SEXT, 0, '1, '1, 0, '0, '0, 5, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_SEXT, 7, 64'h05, 64'h45, 0, '0, '0, 9, 0,
                                  '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_SEXT, 64, '1, '1, 0, '0, '0, 1, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_FIXBIT, 16, 64'h0, 64'hFFFF, 0, '0, '0,
                                  16, 0, '1));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_FIX, 64, '0, '1, 0, '0, '0, 0, 0, '1));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_COPYFIXED, 64, 64'hF0F0_0000_FFFF_0000,
                                  64'hF0F0_FFFF_FFFF_0000, 0, '0, '0, 0, 0,
                                  64'h1234_5678_9ABC_DEF0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_MATCH, 32, 64'h0000_FF00, 64'hFFFF_FF00,
                                  0, '0, '0, 0, 0, 64'h1234_FF00));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_EQ, 8, 64'h0F, 64'hFF, 16, 64'h0F, 64'hFF,
                                  0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_VALID, 64, 64'h8000_0000_0000_0000, '0,
                                  0, '0, '0, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_HASTRUE, 64, '1, '1, 0, '0, '0, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_BITFIXED, 64, '0, 64'h7FFF_FFFF_FFFF_FFFF,
                                  0, '0, '0, 63, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_BITFALSE, 64, '0, '0, 0, '0, '0, 64, 0,
                                  '0));
    cmd_backlog.push_back(make_op(5'd31, 4, '0, '1, 0, '0, '0, 0, 0, '0));
    cmd_backlog.push_back(make_op(tba_pkg::MODE_NOT, 127, '0, '1, 0, '0, '0, 0, 0, '0));

    repeat (RAND_OPS) cmd_backlog.push_back(random_op());

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // drain: all transfers sent, all results seen, then idle before the summary
    while (cmd_backlog.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d requests over %0d distinct mode codes; checked %0d results,",
             n_sent, $countones(modes_hit), n_checked);
    $display("%0d of which were error results.", n_err_res);
    if (n_fail == 0) begin
      $display("ternary_bitvector_alu regression: pass");
    end else begin
      $display("ternary_bitvector_alu regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("Timed out with %0d requests and %0d results outstanding", cmd_backlog.size(),
             expected_results.size());
    $display("ternary_bitvector_alu regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/tba_pkg.sv
rtl/tba_core.sv
rtl/ternary_bitvector_alu.sv
tb/sv/testbench.sv
